// ----- hw/rtl/ucl_pkg.sv -----
// ----------------------------------------------------------------------------
// ucl_pkg: shared types and constants of the command line parser
// Line store depth, command codes, the job passed from front to back, and the
// result payload.
// ----------------------------------------------------------------------------
package ucl_pkg;

   localparam int unsigned LINE_DEPTH = 128;
   localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
   localparam int unsigned LEN_W      = $clog2(LINE_DEPTH + 1);

   localparam logic [31:0] RESET_ADDRESS = 32'h8000_0000;
   localparam logic [31:0] MEM_DEFAULT_LEN = 32'd8;

   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_HASH  = 8'd35;

   typedef enum logic [2:0] {
      CMD_XLOAD   = 3'd0,
      CMD_RUN     = 3'd1,
      CMD_MEM     = 3'd2,
      CMD_MEMSET  = 3'd3,
      CMD_UNKNOWN = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      JOB_ECHO,
      JOB_BACKSPACE,
      JOB_LINE
   } job_kind_type;

   // One job per accepted byte, queued between front and back.
   typedef struct packed {
      job_kind_type     kind;
      logic [7:0]       ch;
      logic [LEN_W-1:0] len;
   } job_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic [2:0]  command;
      logic [31:0] address;
      logic [31:0] argument;
      logic        last;
   } rsp_type;

   function automatic logic is_sep(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
   endfunction

endpackage

// ----- hw/rtl/ucl_if.sv -----
// ----------------------------------------------------------------------------
// ucl_req_if / ucl_rsp_if: valid-ready channels of the parser
// Request carries one received byte, response carries one result item.
// ----------------------------------------------------------------------------
interface ucl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucl_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic [7:0]  tx_byte;
   logic [2:0]  command;
   logic [31:0] address;
   logic [31:0] argument;
   logic        last;
   modport source (output valid, output out_kind, output tx_byte, output command,
                   output address, output argument, output last, input ready);
   modport sink   (input valid, input out_kind, input tx_byte, input command,
                   input address, input argument, input last, output ready);
endinterface

// ----- hw/rtl/ucl_front.sv -----
// ----------------------------------------------------------------------------
// ucl_front: byte intake and line store writer
// Classify each byte, update the line length and write the store.
// ----------------------------------------------------------------------------
module ucl_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              in_byte,
   output logic                    job_valid,
   input  logic                    job_ready,
   output ucl_pkg::job_type        job,
   output logic                    wr_en,
   output logic [ucl_pkg::LINE_AW-1:0] wr_addr,
   output logic [7:0]              wr_data
);
   import ucl_pkg::*;

   logic [LEN_W-1:0] len_ff, len_in;
   logic             xfer;
   logic             is_line;

   // A line job must not be followed by writes until the back has scanned it.
   assign in_ready  = job_ready;
   assign job_valid = in_valid;
   assign xfer      = in_valid && job_ready;
   assign is_line   = (in_byte == CH_CR) || (in_byte == CH_LF);

   always_comb begin
      job.ch  = in_byte;
      job.len = len_ff;
      if (in_byte == CH_BS) begin
         job.kind = JOB_BACKSPACE;
      end else if (is_line) begin
         job.kind = JOB_LINE;
      end else begin
         job.kind = JOB_ECHO;
      end
   end

   assign wr_en   = xfer && !is_line && (in_byte != CH_BS) && (len_ff < LEN_W'(LINE_DEPTH));
   assign wr_addr = len_ff[LINE_AW-1:0];
   assign wr_data = in_byte;

   always_comb begin
      len_in = len_ff;
      if (xfer) begin
         if (in_byte == CH_BS) begin
            if (len_ff != '0) len_in = len_ff - LEN_W'(1);
         end else if (is_line) begin
            len_in = '0;
         end else if (wr_en) begin
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end
endmodule

// ----- hw/rtl/ucl_queue.sv -----
// ----------------------------------------------------------------------------
// ucl_queue: short job queue between front and back
// Two-entry FIFO; after a line job, refuse pushes so no write overtakes its scan.
// ----------------------------------------------------------------------------
module ucl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ucl_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ucl_pkg::job_type  pop_job
);
   import ucl_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       line_ff, line_in;
   logic       push, pop;

   // Stall intake while a line job is queued or the back is still working on
   // it: the back reads the store until it returns to idle.
   assign push_ready = (cnt_ff != 2'd2) && !line_ff;
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_job    = mem_ff[rp_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wp_in   = push ? !wp_ff : wp_ff;
      rp_in   = pop ? !rp_ff : rp_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      line_in = line_ff;
      // Release once the back is idle again and nothing is left queued.
      if (pop_ready && cnt_ff == 2'd0) line_in = 1'b0;
      if (push && push_job.kind == JOB_LINE) line_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         cnt_ff  <= 2'd0;
         line_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cnt_ff  <= cnt_in;
         line_ff <= line_in;
      end
   end
endmodule

// ----- hw/rtl/ucl_back.sv -----
// ----------------------------------------------------------------------------
// ucl_back: job sequencer, line scanner and result output
// Emit echoes, scan the stored line one byte a cycle and issue the command.
// ----------------------------------------------------------------------------
module ucl_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_ready,
   input  ucl_pkg::job_type            job,
   input  logic                        wr_en,
   input  logic [ucl_pkg::LINE_AW-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ucl_pkg::rsp_type            rsp
);
   import ucl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ECHO, ST_READ, ST_SCAN, ST_EXEC, ST_CMD, ST_TAIL
   } st_type;

   logic [7:0] store [LINE_DEPTH];
   logic [7:0] rd_ff;

   st_type           st_ff, st_in;
   job_type          job_ff;
   logic [1:0]       seq_ff, seq_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LINE_AW-1:0] rd_addr;
   // scan state
   logic             inword_ff, inword_in, nonempty_ff, nonempty_in;
   logic             extra_ff, extra_in;
   logic [1:0]       wcnt_ff, wcnt_in;
   logic [3:0]       wlen_ff [3];
   logic [3:0]       wlen_in [3];
   logic             hexok_ff [3];
   logic             hexok_in [3];
   logic [31:0]      hval_ff [3];
   logic [31:0]      hval_in [3];
   logic [7:0]       w0_ff [6];
   logic [7:0]       w0_in [6];
   logic [31:0]      load_ff, load_in, run_ff, run_in, maddr_ff, maddr_in;
   logic [31:0]      arg_ff, arg_in, addr_ff, addr_in;
   cmd_type          cmd_ff, cmd_in;
   rsp_type          out_ff, out_in;
   logic             ov_ff, ov_in;
   logic             out_free;
   logic             a1, a2;
   logic [3:0]       digit;
   logic             dig_ok;

   assign out_free  = !ov_ff || rsp_ready;
   assign rsp_valid = ov_ff;
   assign rsp       = out_ff;
   assign job_ready = (st_ff == ST_IDLE);
   assign rd_addr   = idx_ff[LINE_AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) store[wr_addr] <= wr_data;
      rd_ff <= store[rd_addr];
   end

   always_comb begin
      dig_ok = 1'b1;
      digit  = 4'd0;
      if (rd_ff >= "0" && rd_ff <= "9") begin
         digit = rd_ff[3:0];
      end else if (rd_ff >= "a" && rd_ff <= "f") begin
         digit = rd_ff[3:0] + 4'd9;
      end else begin
         dig_ok = 1'b0;
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (job_valid) st_in = ST_ECHO;
         ST_ECHO: if (out_free) begin
            priority if (job_ff.kind == JOB_BACKSPACE && seq_ff != 2'd2) st_in = ST_ECHO;
            else if (job_ff.kind == JOB_LINE && seq_ff == 2'd0) st_in = ST_ECHO;
            else if (job_ff.kind == JOB_LINE)
               st_in = (job_ff.len == '0) ? ST_EXEC : ST_READ;
            else st_in = ST_IDLE;
         end
         ST_READ: st_in = ST_SCAN;
         ST_SCAN: if (idx_ff == job_ff.len) st_in = ST_EXEC;
         ST_EXEC: st_in = nonempty_ff ? ST_CMD : ST_TAIL;
         ST_CMD:  if (out_free) st_in = ST_TAIL;
         ST_TAIL: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      seq_in = seq_ff;
      idx_in = idx_ff;
      inword_in = inword_ff;
      nonempty_in = nonempty_ff;
      extra_in = extra_ff;
      wcnt_in = wcnt_ff;
      wlen_in = wlen_ff;
      hexok_in = hexok_ff;
      hval_in = hval_ff;
      w0_in = w0_ff;
      load_in = load_ff;
      run_in = run_ff;
      maddr_in = maddr_ff;
      arg_in = arg_ff;
      addr_in = addr_ff;
      cmd_in = cmd_ff;
      out_in = out_ff;
      ov_in = ov_ff && !rsp_ready;
      a1 = hexok_ff[1] && wcnt_ff >= 2'd2 && wlen_ff[1] <= 4'd8;
      a2 = hexok_ff[2] && wcnt_ff == 2'd3 && wlen_ff[2] <= 4'd8;
      unique case (st_ff)
         ST_IDLE: begin
            seq_in = 2'd0;
            idx_in = '0;
            inword_in = 1'b0;
            nonempty_in = 1'b0;
            extra_in = 1'b0;
            wcnt_in = 2'd0;
         end
         ST_ECHO: if (out_free) begin
            ov_in = 1'b1;
            out_in = '0;
            seq_in = seq_ff + 2'd1;
            unique case (job_ff.kind)
               JOB_BACKSPACE: begin
                  out_in.tx_byte = (seq_ff == 2'd1) ? CH_SPACE : CH_BS;
                  out_in.last = (seq_ff == 2'd2);
               end
               JOB_LINE: out_in.tx_byte = (seq_ff == 2'd0) ? job_ff.ch : CH_LF;
               default: begin
                  out_in.tx_byte = job_ff.ch;
                  out_in.last = 1'b1;
               end
            endcase
         end
         // Entry 0 is being read; the next address goes out with each scan step.
         ST_READ: idx_in = LEN_W'(1);
         ST_SCAN: begin
            if (idx_ff != job_ff.len) idx_in = idx_ff + LEN_W'(1);
            if (rd_ff != CH_SPACE && rd_ff != CH_TAB) nonempty_in = 1'b1;
            if (is_sep(rd_ff)) begin
               inword_in = 1'b0;
            end else if (!inword_ff) begin
               inword_in = 1'b1;
               if (wcnt_ff != 2'd3) begin
                  wcnt_in = wcnt_ff + 2'd1;
                  wlen_in[wcnt_ff] = 4'd1;
                  hexok_in[wcnt_ff] = dig_ok;
                  hval_in[wcnt_ff] = {28'd0, digit};
                  if (wcnt_ff == 2'd0) w0_in[0] = rd_ff;
               end else begin
                  // Drop words past the second argument.
                  extra_in = 1'b1;
               end
            end else if (wcnt_ff != 2'd0 && !extra_ff) begin
               if (wlen_ff[wcnt_ff-2'd1] != 4'd15)
                  wlen_in[wcnt_ff-2'd1] = wlen_ff[wcnt_ff-2'd1] + 4'd1;
               hexok_in[wcnt_ff-2'd1] = hexok_ff[wcnt_ff-2'd1] && dig_ok;
               hval_in[wcnt_ff-2'd1] = {hval_ff[wcnt_ff-2'd1][27:0], digit};
               if (wcnt_ff == 2'd1 && wlen_ff[0] < 4'd6)
                  w0_in[wlen_ff[0][2:0]] = rd_ff;
            end
         end
         ST_EXEC: begin
            cmd_in = CMD_UNKNOWN;
            addr_in = '0;
            arg_in = '0;
            if (wcnt_ff != 2'd0) begin
               if (wlen_ff[0] == 4'd5 && w0_ff[0] == "x" && w0_ff[1] == "l" &&
                   w0_ff[2] == "o" && w0_ff[3] == "a" && w0_ff[4] == "d") begin
                  cmd_in = CMD_XLOAD;
                  if (a1) load_in = hval_ff[1];
                  addr_in = a1 ? hval_ff[1] : load_ff;
               end else if (wlen_ff[0] == 4'd3 && w0_ff[0] == "r" &&
                            w0_ff[1] == "u" && w0_ff[2] == "n") begin
                  cmd_in = CMD_RUN;
                  if (a1) run_in = hval_ff[1];
                  addr_in = a1 ? hval_ff[1] : run_ff;
               end else if (w0_ff[0] == "m" && w0_ff[1] == "e" && w0_ff[2] == "m" &&
                            (wlen_ff[0] == 4'd3 || (wlen_ff[0] == 4'd6 &&
                             w0_ff[3] == "s" && w0_ff[4] == "e" && w0_ff[5] == "t"))) begin
                  cmd_in = (wlen_ff[0] == 4'd3) ? CMD_MEM : CMD_MEMSET;
                  addr_in = a1 ? hval_ff[1] : maddr_ff;
                  if (wlen_ff[0] == 4'd3) begin
                     arg_in = a2 ? hval_ff[2] : MEM_DEFAULT_LEN;
                     maddr_in = (a1 ? hval_ff[1] : maddr_ff) +
                                {(a2 ? hval_ff[2][26:0] : 27'd8), 5'd0};
                  end else begin
                     arg_in = a2 ? hval_ff[2] : 32'd0;
                     maddr_in = a1 ? hval_ff[1] : maddr_ff;
                  end
               end
            end
         end
         ST_CMD: if (out_free) begin
            ov_in = 1'b1;
            out_in = '0;
            out_in.out_kind = 1'b1;
            out_in.command = cmd_ff;
            out_in.address = addr_ff;
            out_in.argument = arg_ff;
         end
         ST_TAIL: if (out_free) begin
            ov_in = 1'b1;
            out_in = '0;
            out_in.tx_byte = CH_HASH;
            out_in.last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && job_valid) job_ff <= job;
      idx_ff <= idx_in;
      inword_ff <= inword_in;
      nonempty_ff <= nonempty_in;
      extra_ff <= extra_in;
      wcnt_ff <= wcnt_in;
      wlen_ff <= wlen_in;
      hexok_ff <= hexok_in;
      hval_ff <= hval_in;
      w0_ff <= w0_in;
      arg_ff <= arg_in;
      addr_ff <= addr_in;
      cmd_ff <= cmd_in;
      out_ff <= out_in;
      seq_ff <= seq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         ov_ff    <= 1'b0;
         load_ff  <= RESET_ADDRESS;
         run_ff   <= RESET_ADDRESS;
         maddr_ff <= RESET_ADDRESS;
      end else begin
         st_ff    <= st_in;
         ov_ff    <= ov_in;
         load_ff  <= load_in;
         run_ff   <= run_in;
         maddr_ff <= maddr_in;
      end
   end
endmodule

// ----- hw/rtl/uart_command_line_parser.sv -----
// ----------------------------------------------------------------------------
// uart_command_line_parser: serial console line editor and command parser
// Echoes received bytes, edits a line, and reports the parsed command.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one received byte per transfer; rsp carries result items
//   (echo bytes, one command result per non-empty line, and a closing '#').
//   The front classifies each byte and writes the line store; a two-entry
//   job queue feeds the back, which sequences the results.
// Sequencing:
//   An ordinary byte's echo passes the queue, the back's job register and
//   the output register; a backspace gives three result bytes. An end of
//   line echoes the byte and a line feed, then the back scans the store one
//   byte per cycle through its single read port and issues the command
//   result and the closing '#'. Intake holds from the end-of-line transfer
//   until the back has issued the closing '#' and gone idle.
// Reset:
//   Synchronous: clear the line and set all three addresses to 0x80000000.
// Stall:
//   A result waits in the output register while rsp.ready is low; the back
//   holds, the queue fills, and req.ready drops when it is full.
// ----------------------------------------------------------------------------
module uart_command_line_parser (
   input  logic clock,
   input  logic reset,
   ucl_req_if.sink   req,
   ucl_rsp_if.source rsp
);
   import ucl_pkg::*;

   job_type          f_job, q_job;
   logic             f_valid, f_ready, q_valid, q_ready;
   logic             wr_en;
   logic [LINE_AW-1:0] wr_addr;
   logic [7:0]       wr_data;
   rsp_type          r;

   ucl_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_byte(req.rx_byte),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job),
      .wr_en, .wr_addr, .wr_data
   );

   ucl_queue u_queue (
      .clock, .reset,
      .push_valid(f_valid), .push_ready(f_ready), .push_job(f_job),
      .pop_valid(q_valid), .pop_ready(q_ready), .pop_job(q_job)
   );

   ucl_back u_back (
      .clock, .reset,
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .wr_en, .wr_addr, .wr_data,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(r)
   );

   assign rsp.out_kind = r.out_kind;
   assign rsp.tx_byte  = r.tx_byte;
   assign rsp.command  = r.command;
   assign rsp.address  = r.address;
   assign rsp.argument = r.argument;
   assign rsp.last     = r.last;
endmodule
